### src/ccpe_pkg.sv
// ccpe_pkg: widths, register codes and bus types for the cubic curve point evaluator
// used by ccpe_weight, ccpe_axis and cubic_curve_point_evaluator_core; no dependencies
package ccpe_pkg;

    localparam int COORD_W   = 16;               // coordinate width, signed
    localparam int T_FRAC    = 16;               // fraction bits of t
    localparam int T_W       = T_FRAC + 1;       // t in Q1.T_FRAC
    localparam int SQ_W      = 2 * T_FRAC + 1;   // t*t, u*u, t*u (max 2^(2*T_FRAC))
    localparam int OPB_W     = T_FRAC + 2;       // 3u, 3t, S+2t, S+2u
    localparam int W_W       = 3 * T_FRAC + 1;   // basis weight on scale S^3
    localparam int W_LO      = W_W / 2;          // weight split for the coordinate multiply
    localparam int W_HI      = W_W - W_LO;
    localparam int PH_W      = W_HI + 1 + COORD_W;
    localparam int PL_W      = W_LO + 1 + COORD_W;
    localparam int TERM_W    = W_W + COORD_W + 1;
    localparam int PAIR_W    = TERM_W + 1;
    localparam int ACC_W     = TERM_W + 2;
    localparam int Q_SH      = 3 * T_FRAC;
    localparam int Q_W       = ACC_W - Q_SH;
    localparam int NCTRL     = 4;
    localparam int CFG_IDX_W = 3;
    localparam int W_ST      = 3;                // register stages in ccpe_weight
    localparam int A_ST      = 5;                // register stages in ccpe_axis
    localparam int NUM_ST    = W_ST + A_ST;

    localparam logic [T_W-1:0] T_ONE = T_W'(1) << T_FRAC;
    localparam logic signed [Q_W-1:0] Q_MAX = Q_W'((64'd1 << (COORD_W - 1)) - 64'd1);
    localparam logic signed [Q_W-1:0] Q_MIN = ~Q_MAX;
    localparam logic [ACC_W-1:0] TRUNC_BIAS = (ACC_W'(1) << Q_SH) - ACC_W'(1);
    localparam logic signed [COORD_W-1:0] COORD_MAX = Q_MAX[COORD_W-1:0];
    localparam logic signed [COORD_W-1:0] COORD_MIN = Q_MIN[COORD_W-1:0];

    typedef enum logic {
        OP_BEZIER  = 1'b0,
        OP_HERMITE = 1'b1
    } t_opcode;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_X0 = 3'd0,
        CFG_X1 = 3'd1,
        CFG_X2 = 3'd2,
        CFG_X3 = 3'd3,
        CFG_Y0 = 3'd4,
        CFG_Y1 = 3'd5,
        CFG_Y2 = 3'd6,
        CFG_Y3 = 3'd7
    } t_cfg_idx;

    typedef logic [NCTRL-1:0][COORD_W-1:0] t_ctrl_set;

    // basis weights of one point, shared by both axes
    typedef struct packed {
        logic [NCTRL-1:0][W_W-1:0] w;
        logic                      neg3;   // last weight enters with negative sign
    } t_wgt_bus;

endpackage

### src/cubic_curve_point_evaluator_core.sv
// cubic_curve_point_evaluator_core: top level, control registers, pipeline valid and stall chain
// depends on ccpe_pkg, ccpe_weight, ccpe_axis
//
//  channel  | handshake                    | payload
//  ---------+------------------------------+----------------------------------------
//  input    | i_in_valid / o_in_ready      | i_opcode, i_t_param
//  output   | o_out_valid / i_out_ready    | o_point_x, o_point_y, o_clipped
//  config   | i_cfg_we (no wait)           | i_cfg_idx, i_cfg_wdata
//
// eight register stages: three form the basis weights, five per axis form the sum
// and the saturated result; one transaction per clock while i_out_ready is high
// each stage advances when it is empty or the stage after it advances, so bubbles close
// up and new transactions are taken while a result waits at the output register
// synchronous active-low reset empties the pipeline and clears the control registers
module cubic_curve_point_evaluator_core
    import ccpe_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [COORD_W-1:0]         i_cfg_wdata,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic                       i_opcode,
    input  logic [T_W-1:0]             i_t_param,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic signed [COORD_W-1:0]  o_point_x,
    output logic signed [COORD_W-1:0]  o_point_y,
    output logic                       o_clipped
);

    t_ctrl_set r_ctrl_x, r_ctrl_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctrl_x <= '0;
            r_ctrl_y <= '0;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_X0:  r_ctrl_x[0] <= i_cfg_wdata;
                CFG_X1:  r_ctrl_x[1] <= i_cfg_wdata;
                CFG_X2:  r_ctrl_x[2] <= i_cfg_wdata;
                CFG_X3:  r_ctrl_x[3] <= i_cfg_wdata;
                CFG_Y0:  r_ctrl_y[0] <= i_cfg_wdata;
                CFG_Y1:  r_ctrl_y[1] <= i_cfg_wdata;
                CFG_Y2:  r_ctrl_y[2] <= i_cfg_wdata;
                CFG_Y3:  r_ctrl_y[3] <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // valid bits and per-stage advance
    logic [NUM_ST-1:0] r_v, n_v, en;
    logic              in_acc, out_acc;

    always_comb begin
        en[NUM_ST-1] = !r_v[NUM_ST-1] || i_out_ready;
        for (int k = NUM_ST - 2; k >= 0; k--) begin
            en[k] = !r_v[k] || en[k+1];
        end
    end

    assign o_in_ready  = en[0];
    assign o_out_valid = r_v[NUM_ST-1];
    assign in_acc      = i_in_valid && en[0];
    assign out_acc     = r_v[NUM_ST-1] && i_out_ready;

    always_comb begin
        n_v[0] = en[0] ? in_acc : r_v[0];
        for (int k = 1; k < NUM_ST; k++) begin
            n_v[k] = en[k] ? r_v[k-1] : r_v[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= n_v;
        end
    end

    t_wgt_bus wgt;
    logic     clip_x, clip_y;

    ccpe_weight u_weight (
        .i_clk     (i_clk),
        .i_en      (en[W_ST-1:0]),
        .i_opcode  (t_opcode'(i_opcode)),
        .i_t_param (i_t_param),
        .o_wgt     (wgt)
    );

    ccpe_axis u_axis_x (
        .i_clk   (i_clk),
        .i_en    (en[NUM_ST-1:W_ST]),
        .i_wgt   (wgt),
        .i_ctrl  (r_ctrl_x),
        .o_point (o_point_x),
        .o_clip  (clip_x)
    );

    ccpe_axis u_axis_y (
        .i_clk   (i_clk),
        .i_en    (en[NUM_ST-1:W_ST]),
        .i_wgt   (wgt),
        .i_ctrl  (r_ctrl_y),
        .o_point (o_point_y),
        .o_clip  (clip_y)
    );

    assign o_clipped = clip_x || clip_y;

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("pipeline not empty after reset");

    a_full_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (&r_v) && !i_out_ready |-> !o_in_ready)
        else $error("input taken while every stage is full and output stalled");

    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && !out_acc |=> $countones(r_v) == $past($countones(r_v)) + 1)
        else $error("accepted transaction not held in pipeline");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[NUM_ST-2] && !en[NUM_ST-2] |=> r_v[NUM_ST-2])
        else $error("stalled stage lost its transaction");

    a_clip_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_clipped |-> (o_point_x == COORD_MAX || o_point_x == COORD_MIN ||
                                      o_point_y == COORD_MAX || o_point_y == COORD_MIN))
        else $error("clipped set without a coordinate at a bound");

endmodule

### src/ccpe_weight.sv
// ccpe_weight: clamps t and forms the four exact cubic basis weights in three stages
// depends on ccpe_pkg
module ccpe_weight
    import ccpe_pkg::*;
(
    input  logic             i_clk,
    input  logic [W_ST-1:0]  i_en,
    input  t_opcode          i_opcode,
    input  logic [T_W-1:0]   i_t_param,
    output t_wgt_bus         o_wgt
);

    // stage 0: clamp t, u = 1 - t
    logic [T_W-1:0] n0_t, n0_u;
    logic [T_W-1:0] r0_t, r0_u;
    t_opcode        r0_op;

    always_comb begin
        n0_t = (i_t_param > T_ONE) ? T_ONE : i_t_param;
        n0_u = T_ONE - n0_t;
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r0_t  <= n0_t;
            r0_u  <= n0_u;
            r0_op <= i_opcode;
        end
    end

    // stage 1: quadratic products and second operands
    logic [2*T_W-1:0]               tt_full, uu_full, tu_full;
    logic [NCTRL-1:0][OPB_W-1:0]    n1_b;
    logic [SQ_W-1:0]                r1_tt, r1_uu, r1_tu;
    logic [NCTRL-1:0][OPB_W-1:0]    r1_b;
    t_opcode                        r1_op;
    logic [OPB_W-1:0]               t_x, u_x;

    always_comb begin
        tt_full = r0_t * r0_t;
        uu_full = r0_u * r0_u;
        tu_full = r0_t * r0_u;
        t_x     = OPB_W'(r0_t);
        u_x     = OPB_W'(r0_u);
        case (r0_op)
            OP_BEZIER: begin
                n1_b[0] = u_x;
                n1_b[1] = (u_x << 1) + u_x;
                n1_b[2] = (t_x << 1) + t_x;
                n1_b[3] = t_x;
            end
            OP_HERMITE: begin
                n1_b[0] = OPB_W'(T_ONE) + (t_x << 1);
                n1_b[1] = OPB_W'(T_ONE) + (u_x << 1);
                n1_b[2] = u_x;
                n1_b[3] = u_x;
            end
            default: begin
                n1_b = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r1_tt <= tt_full[SQ_W-1:0];
            r1_uu <= uu_full[SQ_W-1:0];
            r1_tu <= tu_full[SQ_W-1:0];
            r1_b  <= n1_b;
            r1_op <= r0_op;
        end
    end

    // stage 2: cubic weights, each at most S^3
    logic [NCTRL-1:0][SQ_W-1:0]         a;
    logic [NCTRL-1:0][SQ_W+OPB_W-1:0]   prod;
    t_wgt_bus                           n2_wgt;
    t_wgt_bus                           r2_wgt;

    always_comb begin
        a[0] = r1_uu;
        a[1] = (r1_op == OP_HERMITE) ? r1_tt : r1_tu;
        a[2] = r1_tu;
        a[3] = r1_tt;
        for (int i = 0; i < NCTRL; i++) begin
            prod[i]     = a[i] * r1_b[i];
            n2_wgt.w[i] = prod[i][W_W-1:0];
        end
        n2_wgt.neg3 = (r1_op == OP_HERMITE);
    end

    always_ff @(posedge i_clk) begin
        if (i_en[2]) begin
            r2_wgt <= n2_wgt;
        end
    end

    assign o_wgt = r2_wgt;

endmodule

### src/ccpe_axis.sv
// ccpe_axis: weighted sum of four control values for one axis, then truncate and saturate
// depends on ccpe_pkg; weights come from ccpe_weight
module ccpe_axis
    import ccpe_pkg::*;
(
    input  logic                       i_clk,
    input  logic [A_ST-1:0]            i_en,
    input  t_wgt_bus                   i_wgt,
    input  t_ctrl_set                  i_ctrl,
    output logic signed [COORD_W-1:0]  o_point,
    output logic                       o_clip
);

    // stage 0: weight split in two halves times the signed control value
    logic signed [PH_W-1:0] n0_ph [NCTRL];
    logic signed [PL_W-1:0] n0_pl [NCTRL];
    logic signed [PH_W-1:0] r0_ph [NCTRL];
    logic signed [PL_W-1:0] r0_pl [NCTRL];
    logic                   r0_neg3;

    always_comb begin
        for (int i = 0; i < NCTRL; i++) begin
            n0_ph[i] = $signed({1'b0, i_wgt.w[i][W_W-1:W_LO]}) * $signed(i_ctrl[i]);
            n0_pl[i] = $signed({1'b0, i_wgt.w[i][W_LO-1:0]}) * $signed(i_ctrl[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r0_ph   <= n0_ph;
            r0_pl   <= n0_pl;
            r0_neg3 <= i_wgt.neg3;
        end
    end

    // stage 1: recombine halves into exact terms
    logic signed [TERM_W-1:0] n1_term [NCTRL];
    logic signed [TERM_W-1:0] r1_term [NCTRL];
    logic                     r1_neg3;

    always_comb begin
        for (int i = 0; i < NCTRL; i++) begin
            n1_term[i] = (TERM_W'(r0_ph[i]) <<< W_LO) + TERM_W'(r0_pl[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r1_term <= n1_term;
            r1_neg3 <= r0_neg3;
        end
    end

    // stage 2: pair sums, hermite end tangent subtracts
    logic signed [PAIR_W-1:0] n2_s01, n2_s23, r2_s01, r2_s23;

    always_comb begin
        n2_s01 = PAIR_W'(r1_term[0]) + PAIR_W'(r1_term[1]);
        if (r1_neg3) begin
            n2_s23 = PAIR_W'(r1_term[2]) - PAIR_W'(r1_term[3]);
        end else begin
            n2_s23 = PAIR_W'(r1_term[2]) + PAIR_W'(r1_term[3]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[2]) begin
            r2_s01 <= n2_s01;
            r2_s23 <= n2_s23;
        end
    end

    // stage 3: full sum on scale S^3
    logic signed [ACC_W-1:0] n3_acc, r3_acc;

    assign n3_acc = ACC_W'(r2_s01) + ACC_W'(r2_s23);

    always_ff @(posedge i_clk) begin
        if (i_en[3]) begin
            r3_acc <= n3_acc;
        end
    end

    // stage 4: divide by S^3 toward zero, clamp to coordinate range
    logic [ACC_W-1:0]          biased;
    logic signed [Q_W-1:0]     quot;
    logic signed [COORD_W-1:0] n4_point, r4_point;
    logic                      n4_clip, r4_clip;

    always_comb begin
        // negative sums get S^3-1 added so the arithmetic shift rounds toward zero
        biased = r3_acc + (r3_acc[ACC_W-1] ? TRUNC_BIAS : '0);
        quot   = $signed(biased[ACC_W-1:Q_SH]);
        if (quot > Q_MAX) begin
            n4_point = COORD_MAX;
            n4_clip  = 1'b1;
        end else if (quot < Q_MIN) begin
            n4_point = COORD_MIN;
            n4_clip  = 1'b1;
        end else begin
            n4_point = quot[COORD_W-1:0];
            n4_clip  = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[4]) begin
            r4_point <= n4_point;
            r4_clip  <= n4_clip;
        end
    end

    assign o_point = r4_point;
    assign o_clip  = r4_clip;

endmodule
